// ----- sv/tsd_pkg.sv -----
`timescale 1ns / 1ps
package tsd_pkg;

  localparam int unsigned NumShadow = 65;
  localparam int unsigned NumEnc = 64;
  localparam int unsigned IdxW = 7;
  localparam int unsigned DefPageBytes = 4096;

  localparam logic [5:0] EcWfx = 6'b000001;
  localparam logic [5:0] EcFp = 6'b000111;
  localparam logic [5:0] EcHvc = 6'b010110;
  localparam logic [5:0] EcSys = 6'b011000;
  localparam logic [5:0] EcDabt = 6'b100100;

  typedef enum logic [3:0] {
    ActWfx = 4'd0,
    ActFp = 4'd1,
    ActHvc = 4'd2,
    ActSysRd = 4'd3,
    ActSysWr = 4'd4,
    ActUnmatched = 4'd5,
    ActMapPage = 4'd6,
    ActMmioRd = 4'd7,
    ActMmioWr = 4'd8,
    ActHalt = 4'd9,
    ActLoaded = 4'd10
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [5:0]  ec;
    logic        pc_adv;
    logic [4:0]  treg;
    logic        rd_en;
    logic        wr_en;
    logic [IdxW-1:0] idx;
    logic [63:0] addr;
    logic [63:0] gval;
  } op_t;

  function automatic logic [15:0] sr_key(input int a, input int b, input int c,
                                         input int d, input int e);
    sr_key = 16'((a << 14) | (b << 11) | (c << 7) | (d << 3) | e);
  endfunction

  // Returns a match flag, the writable flag and the entry number.
  function automatic logic [8:0] sr_lookup(input logic [15:0] key);
    logic [15:0] k [NumEnc];
    logic [NumEnc-1:0] wr;
    logic [8:0] r;
    k[0]=sr_key(3,0,1,0,0); k[1]=sr_key(3,0,2,0,0); k[2]=sr_key(3,0,2,0,1);
    k[3]=sr_key(3,0,2,0,2); k[4]=sr_key(3,0,5,2,0); k[5]=sr_key(3,0,6,0,0);
    k[6]=sr_key(3,0,5,1,0); k[7]=sr_key(3,0,5,1,1); k[8]=sr_key(3,0,10,2,0);
    k[9]=sr_key(3,0,10,3,0); k[10]=sr_key(3,0,13,0,1); k[11]=sr_key(3,0,1,0,2);
    k[12]=sr_key(3,0,4,0,1); k[13]=sr_key(3,3,4,4,0); k[14]=sr_key(3,3,4,4,1);
    k[15]=sr_key(3,0,0,0,0); k[16]=sr_key(3,0,0,0,5); k[17]=sr_key(3,0,7,4,0);
    k[18]=sr_key(3,0,4,1,0); k[19]=sr_key(3,4,4,1,0); k[20]=sr_key(3,0,4,0,0);
    k[21]=sr_key(3,3,13,0,2); k[22]=sr_key(3,0,13,0,4); k[23]=sr_key(3,3,13,0,3);
    k[24]=sr_key(3,0,12,0,0); k[25]=sr_key(3,0,1,0,1);
    k[26]=sr_key(3,0,0,1,0); k[27]=sr_key(3,0,0,1,1); k[28]=sr_key(3,0,0,1,4);
    k[29]=sr_key(3,0,0,1,5); k[30]=sr_key(3,0,0,1,6); k[31]=sr_key(3,0,0,1,7);
    k[32]=sr_key(3,0,0,2,0); k[33]=sr_key(3,0,0,2,1); k[34]=sr_key(3,0,0,2,2);
    k[35]=sr_key(3,0,0,2,3); k[36]=sr_key(3,0,0,2,4); k[37]=sr_key(3,0,0,2,5);
    k[38]=sr_key(3,0,0,3,0); k[39]=sr_key(3,0,0,3,1); k[40]=sr_key(3,0,0,3,2);
    k[41]=sr_key(3,0,0,4,0); k[42]=sr_key(3,0,0,4,1); k[43]=sr_key(3,0,0,5,0);
    k[44]=sr_key(3,0,0,5,1); k[45]=sr_key(3,0,0,6,0); k[46]=sr_key(3,0,0,6,1);
    k[47]=sr_key(3,0,0,7,0); k[48]=sr_key(3,0,0,7,1); k[49]=sr_key(3,0,0,5,4);
    k[50]=sr_key(3,0,0,5,5); k[51]=sr_key(3,3,0,0,1); k[52]=sr_key(3,1,0,0,0);
    k[53]=sr_key(3,1,0,0,1); k[54]=sr_key(3,2,0,0,0); k[55]=sr_key(3,1,0,0,7);
    k[56]=sr_key(3,0,0,0,6); k[57]=sr_key(3,0,14,1,0); k[58]=sr_key(3,3,14,2,1);
    k[59]=sr_key(3,3,14,2,2); k[60]=sr_key(3,3,14,2,0); k[61]=sr_key(3,3,14,3,1);
    k[62]=sr_key(3,3,14,3,2); k[63]=sr_key(3,3,14,3,0);
    wr = '0;
    wr[25:0] = '1;
    wr[54] = 1'b1;
    wr[63:57] = '1;
    r = '0;
    for (int i = NumEnc - 1; i >= 0; i--) begin
      if (k[i] == key) begin
        r = {1'b1, wr[i], 7'(i)};
      end
    end
    sr_lookup = r;
  endfunction

endpackage

// ----- sv/tsd_ram.sv -----
`timescale 1ns / 1ps
module tsd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ----- sv/tsd_front.sv -----
`timescale 1ns / 1ps
module tsd_front #(
  parameter int unsigned PageBytes = tsd_pkg::DefPageBytes
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic             cmd_i,
  input  logic [31:0]      syndrome_i,
  input  logic [63:0]      fault_address_i,
  input  logic [63:0]      guest_reg_value_i,
  input  logic [6:0]       shadow_index_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output tsd_pkg::op_t     q_op_o
);
  import tsd_pkg::*;

  localparam logic [63:0] PageMask = ~(64'(PageBytes) - 64'd1);

  op_t op, op_q;
  logic full_q;
  logic [8:0] lk;
  logic [5:0] ec;

  assign ec = syndrome_i[31:26];
  assign lk = sr_lookup({syndrome_i[21:20], syndrome_i[16:14], syndrome_i[13:10],
                         syndrome_i[4:1], syndrome_i[19:17]});

  always_comb begin
    op = '0;
    op.gval = guest_reg_value_i;
    op.action = ActHalt;
    if (cmd_i) begin
      op.action = ActLoaded;
      op.idx = shadow_index_i;
      op.wr_en = (shadow_index_i < IdxW'(NumShadow));
    end else begin
      op.ec = ec;
      unique case (ec)
        EcWfx: begin
          op.action = ActWfx;
          op.pc_adv = 1'b1;
        end
        EcFp: op.action = ActFp;
        EcHvc: op.action = ActHvc;
        EcSys: begin
          op.treg = syndrome_i[9:5];
          op.idx = lk[6:0];
          if (!lk[8] || (!syndrome_i[0] && !lk[7])) begin
            op.action = ActUnmatched;
          end else if (syndrome_i[0]) begin
            op.action = ActSysRd;
            op.pc_adv = 1'b1;
            op.rd_en = 1'b1;
          end else begin
            op.action = ActSysWr;
            op.pc_adv = 1'b1;
            op.wr_en = 1'b1;
          end
        end
        EcDabt: begin
          if (syndrome_i[5:2] == 4'd1) begin
            op.action = ActMapPage;
            op.addr = fault_address_i & PageMask;
          end else begin
            op.treg = syndrome_i[20:16];
            op.addr = fault_address_i;
            op.pc_adv = 1'b1;
            op.action = syndrome_i[6] ? ActMmioWr : ActMmioRd;
          end
        end
        default: op.action = ActHalt;
      endcase
    end
  end

  assign ready_o = !full_q || q_ready_i;
  assign q_valid_o = full_q;
  assign q_op_o = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (ready_o) begin
      full_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      op_q <= op;
    end
  end
endmodule

// ----- sv/tsd_back.sv -----
`timescale 1ns / 1ps
module tsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  tsd_pkg::op_t  q_op_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [3:0]    action_o,
  output logic [5:0]    exception_class_o,
  output logic          pc_advance_o,
  output logic [4:0]    target_reg_o,
  output logic [63:0]   read_data_o,
  output logic [63:0]   request_address_o,
  output logic [63:0]   write_data_o
);
  import tsd_pkg::*;

  // Reset clearing pass over the shadow file.
  logic [IdxW-1:0] clr_q;
  logic clearing;
  logic take, full_q, rd_q;
  logic [63:0] ram_rd;
  op_t op_q;
  logic we;
  logic [IdxW-1:0] waddr;
  logic [63:0] wdata;

  assign clearing = (clr_q != IdxW'(NumShadow));
  assign q_ready_o = !clearing && (!full_q || ready_i);
  assign take = q_ready_o && q_valid_i;
  assign we = clearing || (take && q_op_i.wr_en);
  assign waddr = clearing ? clr_q : q_op_i.idx;
  assign wdata = clearing ? 64'd0 : q_op_i.gval;

  tsd_ram #(.Width(64), .Depth(NumShadow)) u_ram (
    .clk_i,
    .we_i(we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i(take),
    .raddr_i(q_op_i.idx),
    .rdata_o(ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      full_q <= 1'b0;
    end else begin
      if (clearing) begin
        clr_q <= clr_q + 1'b1;
      end
      if (!full_q || ready_i) begin
        full_q <= take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= q_op_i;
      rd_q <= q_op_i.rd_en;
    end
  end

  assign valid_o = full_q;
  assign action_o = op_q.action;
  assign exception_class_o = op_q.ec;
  assign pc_advance_o = op_q.pc_adv;
  assign target_reg_o = op_q.treg;
  assign read_data_o = rd_q ? ram_rd : 64'd0;
  assign request_address_o = op_q.addr;
  assign write_data_o = (op_q.action == ActMmioWr) ? op_q.gval : 64'd0;

  a_no_take_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !take) else $error("item taken during clear");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(action_o)) else $error("result lost");
  a_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !(q_op_i.rd_en && q_op_i.wr_en)) else $error("read and write together");
endmodule

// ----- sv/trap_syndrome_decoder_sysreg_shadow.sv -----
`timescale 1ns / 1ps
// Trap syndrome decoder with a shadow system-register file.
// Requests arrive on the valid_i/ready_o channel: cmd_i selects a trap to
// decode or a host load of one shadow entry. Each request yields exactly one
// result on the valid_o/ready_i channel, carrying the action and its fields.
// The front stage decodes the syndrome and matches the register encoding
// against a constant table; one queue register then hands the decoded
// request to the back stage, which accesses the shadow file and holds the
// result in an output register.
// One request per cycle is sustained while the receiver takes results and
// the clearing pass is over, set by the queue register and the output
// register, each of which passes one request on every cycle.
// After reset the back stage clears the 65 shadow entries, one per cycle,
// and until that pass ends at most one request is accepted into the queue.
// When the receiver stalls, the output and queue registers fill and
// ready_o falls; nothing is dropped.
module trap_syndrome_decoder_sysreg_shadow #(
  parameter int unsigned PageBytes = tsd_pkg::DefPageBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        cmd_i,
  input  logic [31:0] syndrome_i,
  input  logic [63:0] fault_address_i,
  input  logic [63:0] guest_reg_value_i,
  input  logic [6:0]  shadow_index_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [3:0]  action_o,
  output logic [5:0]  exception_class_o,
  output logic        pc_advance_o,
  output logic [4:0]  target_reg_o,
  output logic [63:0] read_data_o,
  output logic [63:0] request_address_o,
  output logic [63:0] write_data_o
);
  import tsd_pkg::*;

  logic q_valid, q_ready;
  op_t q_op;

  tsd_front #(.PageBytes(PageBytes)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .cmd_i, .syndrome_i, .fault_address_i,
    .guest_reg_value_i, .shadow_index_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_op_o(q_op)
  );

  tsd_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_op_i(q_op),
    .valid_o, .ready_i, .action_o, .exception_class_o, .pc_advance_o,
    .target_reg_o, .read_data_o, .request_address_o, .write_data_o
  );
endmodule
